### design/rau_pkg.sv
package rau_pkg;

  localparam int RAU_WIDTH = 32;
  localparam int FIELD_W   = 32;
  localparam int MAG_W     = 64;

  localparam logic [1:0] MODE_NORM = 2'd0;
  localparam logic [1:0] MODE_ADD  = 2'd1;
  localparam logic [1:0] MODE_MUL  = 2'd2;
  localparam logic [1:0] MODE_NEG  = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_ZDIV = 2'd2;

  typedef enum logic {
    ALU_DIV = 1'b0,
    ALU_MUL = 1'b1
  } alu_op_t;

  // sign and magnitude; a zero magnitude is never negative
  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } snum_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic [FIELD_W-1:0] a_num;
    logic [FIELD_W-1:0] a_den;
    logic [FIELD_W-1:0] b_num;
    logic [FIELD_W-1:0] b_den;
  } rau_in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] res_num;
    logic [FIELD_W-1:0] res_den;
    logic [1:0]         status;
  } rau_out_t;

  function automatic snum_t mk(input logic neg, input logic [MAG_W-1:0] mag);
    snum_t s;
    s.neg = neg && (mag != '0);
    s.mag = mag;
    return s;
  endfunction

endpackage

### design/rau_alu.sv
module rau_alu (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  rau_pkg::alu_op_t op,
  input  rau_pkg::snum_t x,
  input  rau_pkg::snum_t y,
  output logic           done,
  output rau_pkg::snum_t quo,
  output rau_pkg::snum_t rem
);
  import rau_pkg::*;

  localparam int CNT_W = $clog2(MAG_W);

  logic             run;
  logic [CNT_W-1:0] cnt;
  alu_op_t          op_r;
  logic             xneg;
  logic             yneg;
  logic [MAG_W:0]   acc;
  logic [MAG_W-1:0] sh;
  logic [MAG_W-1:0] dv;
  logic [MAG_W-1:0] qr;
  logic [MAG_W:0]   trial;
  logic             take;

  // one quotient bit (restoring) or one multiplier bit (shift and add) per cycle
  assign trial = {acc[MAG_W-1:0], sh[MAG_W-1]};
  assign take  = trial >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        cnt  <= CNT_W'(MAG_W - 1);
        op_r <= op;
        xneg <= x.neg;
        yneg <= y.neg;
        acc  <= '0;
        sh   <= x.mag;
        dv   <= y.mag;
        qr   <= '0;
      end else if (run) begin
        if (op_r == ALU_DIV) begin
          acc <= take ? (trial - {1'b0, dv}) : trial;
          qr  <= {qr[MAG_W-2:0], take};
          sh  <= {sh[MAG_W-2:0], 1'b0};
        end else begin
          if (dv[0]) begin
            acc <= {1'b0, acc[MAG_W-1:0] + sh};
          end
          sh <= {sh[MAG_W-2:0], 1'b0};
          dv <= {1'b0, dv[MAG_W-1:1]};
        end
        if (cnt == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - 1'b1;
      end
    end
  end

  assign quo = (op_r == ALU_DIV) ? mk(xneg ^ yneg, qr) : mk(xneg ^ yneg, acc[MAG_W-1:0]);
  assign rem = mk(xneg, acc[MAG_W-1:0]);

endmodule

### design/rational_arithmetic_unit.sv
// Channel   Ports                 Direction  Transfer
// command   start, busy, cmd      in         taken when start is high and busy is low
// result    done, result          out        valid for the one cycle that done is high
//
// One transaction runs a short micro-program over one shared divide/multiply unit.
// Each divide or multiply is issued, runs bit-serially over the 64-bit magnitudes and is
// then written back. An item's duration grows with its divides, multiplies and Euclid
// steps, and the GCD loop can run long; special cases settled in prep skip the arithmetic.
// Synchronous reset returns the sequencer to idle and drops any pending result.
// The receiver cannot stall: the result is shown for exactly one cycle, and a new
// command may be taken in that same cycle.
module rational_arithmetic_unit #(
  parameter int WIDTH = rau_pkg::RAU_WIDTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  rau_pkg::rau_in_t  cmd,
  output logic              done,
  output rau_pkg::rau_out_t result
);
  import rau_pkg::*;

  // operands and results live in signed OPW bits
  localparam int OPW = (WIDTH < FIELD_W) ? WIDTH : FIELD_W;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PREP  = 7'b0000010,
    S_ISSUE = 7'b0000100,
    S_GCD   = 7'b0001000,
    S_GWAIT = 7'b0010000,
    S_WAIT  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  typedef enum logic [2:0] {
    K_GCD,
    K_DIV,
    K_MUL,
    K_ADD,
    K_END
  } kind_t;

  typedef enum logic [2:0] {
    R_AN, R_AD, R_BN, R_BD, R_G, R_H, R_RN, R_RD
  } rsel_t;

  typedef struct packed {
    kind_t kind;
    rsel_t x;
    rsel_t y;
    rsel_t d;
  } uop_t;

  localparam snum_t S_ZERO = '{neg: 1'b0, mag: '0};
  localparam snum_t S_ONE  = '{neg: 1'b0, mag: MAG_W'(1)};

  state_t     state;
  logic [1:0] mode;
  logic [3:0] step;
  logic       zdiv;
  snum_t      an, ad, bn, bd, g, h, rn, rd, ga, gb;

  uop_t       uop;
  snum_t      opx, opy, sum, pn;
  logic       wb_en;
  snum_t      wb_val;
  logic       alu_start;
  alu_op_t    alu_op;
  snum_t      alu_x, alu_y, alu_quo, alu_rem;
  logic       alu_done;

  function automatic snum_t from_field(input logic [FIELD_W-1:0] v);
    logic [OPW-1:0] lo;
    lo = v[OPW-1:0];
    return mk(lo[OPW-1], {{(MAG_W-OPW){1'b0}}, lo[OPW-1] ? (~lo + 1'b1) : lo});
  endfunction

  function automatic logic [FIELD_W-1:0] to_field(input snum_t s);
    logic [MAG_W-1:0] bits;
    bits = s.neg ? (~s.mag + 1'b1) : s.mag;
    return bits[FIELD_W-1:0];
  endfunction

  function automatic logic fits(input snum_t s);
    logic [MAG_W-1:0] lim;
    lim = MAG_W'(1) << (OPW - 1);
    return s.neg ? (s.mag <= lim) : (s.mag < lim);
  endfunction

  function automatic logic is_zero(input snum_t s);
    return s.mag == '0;
  endfunction

  function automatic logic is_one(input snum_t s);
    return !s.neg && (s.mag == MAG_W'(1));
  endfunction

  function automatic snum_t s_add(input snum_t a, input snum_t b);
    if (a.neg == b.neg) return mk(a.neg, a.mag + b.mag);
    if (a.mag >= b.mag) return mk(a.neg, a.mag - b.mag);
    return mk(b.neg, b.mag - a.mag);
  endfunction

  // micro-programs: one each for add and multiply, one shared by normalise and negate
  function automatic uop_t decode(input logic [1:0] m, input logic [3:0] s);
    uop_t u;
    u = '{kind: K_END, x: R_RN, y: R_RD, d: R_RN};
    case (m)
      MODE_ADD: begin
        case (s)
          4'd0:    u = '{kind: K_GCD, x: R_AD, y: R_BD, d: R_G};
          4'd1:    u = '{kind: K_DIV, x: R_AD, y: R_G,  d: R_H};
          4'd2:    u = '{kind: K_MUL, x: R_H,  y: R_BD, d: R_RD};
          4'd3:    u = '{kind: K_DIV, x: R_RD, y: R_AD, d: R_H};
          4'd4:    u = '{kind: K_MUL, x: R_AN, y: R_H,  d: R_RN};
          4'd5:    u = '{kind: K_DIV, x: R_RD, y: R_BD, d: R_H};
          4'd6:    u = '{kind: K_MUL, x: R_BN, y: R_H,  d: R_G};
          4'd7:    u = '{kind: K_ADD, x: R_RN, y: R_G,  d: R_RN};
          4'd8:    u = '{kind: K_GCD, x: R_RN, y: R_RD, d: R_G};
          4'd9:    u = '{kind: K_DIV, x: R_RN, y: R_G,  d: R_RN};
          4'd10:   u = '{kind: K_DIV, x: R_RD, y: R_G,  d: R_RD};
          default: u = '{kind: K_END, x: R_RN, y: R_RD, d: R_RN};
        endcase
      end
      MODE_MUL: begin
        case (s)
          4'd0:    u = '{kind: K_GCD, x: R_AN, y: R_BD, d: R_G};
          4'd1:    u = '{kind: K_GCD, x: R_BN, y: R_AD, d: R_H};
          4'd2:    u = '{kind: K_DIV, x: R_AN, y: R_G,  d: R_AN};
          4'd3:    u = '{kind: K_DIV, x: R_BD, y: R_G,  d: R_BD};
          4'd4:    u = '{kind: K_DIV, x: R_BN, y: R_H,  d: R_BN};
          4'd5:    u = '{kind: K_DIV, x: R_AD, y: R_H,  d: R_AD};
          4'd6:    u = '{kind: K_MUL, x: R_AN, y: R_BN, d: R_RN};
          4'd7:    u = '{kind: K_MUL, x: R_AD, y: R_BD, d: R_RD};
          default: u = '{kind: K_END, x: R_RN, y: R_RD, d: R_RN};
        endcase
      end
      default: begin
        case (s)
          4'd0:    u = '{kind: K_GCD, x: R_RN, y: R_RD, d: R_G};
          4'd1:    u = '{kind: K_DIV, x: R_RN, y: R_G,  d: R_RN};
          4'd2:    u = '{kind: K_DIV, x: R_RD, y: R_G,  d: R_RD};
          default: u = '{kind: K_END, x: R_RN, y: R_RD, d: R_RN};
        endcase
      end
    endcase
    return u;
  endfunction

  assign uop = decode(mode, step);

  always_comb begin
    case (uop.x)
      R_AN:    opx = an;
      R_AD:    opx = ad;
      R_BN:    opx = bn;
      R_BD:    opx = bd;
      R_G:     opx = g;
      R_H:     opx = h;
      R_RN:    opx = rn;
      R_RD:    opx = rd;
      default: opx = S_ZERO;
    endcase
  end

  always_comb begin
    case (uop.y)
      R_AN:    opy = an;
      R_AD:    opy = ad;
      R_BN:    opy = bn;
      R_BD:    opy = bd;
      R_G:     opy = g;
      R_H:     opy = h;
      R_RN:    opy = rn;
      R_RD:    opy = rd;
      default: opy = S_ZERO;
    endcase
  end

  assign sum = s_add(opx, opy);
  assign pn  = (mode == MODE_NEG) ? mk(!an.neg, an.mag) : an;

  // write back: sum of the add step, finished GCD, or shared unit result
  always_comb begin
    wb_en  = 1'b0;
    wb_val = alu_quo;
    case (state)
      S_ISSUE: begin
        wb_en  = (uop.kind == K_ADD);
        wb_val = sum;
      end
      S_GCD: begin
        wb_en  = is_zero(ga);
        wb_val = gb;
      end
      S_WAIT: begin
        wb_en  = alu_done;
        wb_val = alu_quo;
      end
      default: wb_en = 1'b0;
    endcase
  end

  // Euclid steps reuse the divider for the truncating remainder
  assign alu_start = ((state == S_ISSUE) && ((uop.kind == K_DIV) || (uop.kind == K_MUL)))
                  || ((state == S_GCD) && !is_zero(ga));
  assign alu_op    = ((state == S_ISSUE) && (uop.kind == K_MUL)) ? ALU_MUL : ALU_DIV;
  assign alu_x     = (state == S_GCD) ? gb : opx;
  assign alu_y     = (state == S_GCD) ? ga : opy;

  rau_alu u_alu (
    .clk   (clk),
    .rst   (rst),
    .start (alu_start),
    .op    (alu_op),
    .x     (alu_x),
    .y     (alu_y),
    .done  (alu_done),
    .quo   (alu_quo),
    .rem   (alu_rem)
  );

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;

      if (wb_en) begin
        case (uop.d)
          R_AN:    an <= wb_val;
          R_AD:    ad <= wb_val;
          R_BN:    bn <= wb_val;
          R_BD:    bd <= wb_val;
          R_G:     g  <= wb_val;
          R_H:     h  <= wb_val;
          R_RN:    rn <= wb_val;
          R_RD:    rd <= wb_val;
          default: rn <= wb_val;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (start) begin
            mode  <= cmd.mode;
            an    <= from_field(cmd.a_num);
            ad    <= from_field(cmd.a_den);
            bn    <= from_field(cmd.b_num);
            bd    <= from_field(cmd.b_den);
            step  <= '0;
            zdiv  <= 1'b0;
            state <= S_PREP;
          end
        end

        // settle the special cases before any arithmetic
        S_PREP: begin
          case (mode)
            MODE_ADD: begin
              if (is_zero(bn)) begin
                rn    <= an;
                rd    <= ad;
                state <= S_OUT;
              end else if (is_zero(ad) || is_zero(bd)) begin
                rn    <= S_ONE;
                rd    <= S_ZERO;
                state <= S_OUT;
              end else if (is_zero(an)) begin
                rn    <= bn;
                rd    <= bd;
                state <= S_OUT;
              end else begin
                state <= S_ISSUE;
              end
            end
            MODE_MUL: state <= S_ISSUE;
            default: begin
              if (is_zero(pn) && is_zero(ad)) begin
                rn    <= pn;
                rd    <= ad;
                state <= S_OUT;
              end else if (is_zero(ad)) begin
                rn    <= S_ONE;
                rd    <= S_ZERO;
                state <= S_OUT;
              end else if (is_zero(pn)) begin
                rn    <= S_ZERO;
                rd    <= S_ONE;
                state <= S_OUT;
              end else begin
                rn    <= pn;
                rd    <= ad;
                state <= S_ISSUE;
              end
            end
          endcase
        end

        S_ISSUE: begin
          case (uop.kind)
            K_END: state <= S_OUT;
            K_GCD: begin
              ga    <= opx;
              gb    <= opy;
              state <= S_GCD;
            end
            K_DIV, K_MUL: state <= S_WAIT;
            K_ADD: begin
              step <= step + 1'b1;
              if (is_zero(sum)) begin
                rd    <= S_ONE;
                state <= S_OUT;
              end else if (is_one(rd) || is_one(sum)) begin
                state <= S_OUT;
              end
            end
            default: state <= S_OUT;
          endcase
        end

        S_GCD: begin
          if (is_zero(ga)) begin
            step <= step + 1'b1;
            // multiply with a zero cross GCD has no quotient
            if ((mode == MODE_MUL) && (step == 4'd1) && (is_zero(g) || is_zero(gb))) begin
              zdiv  <= 1'b1;
              state <= S_OUT;
            end else begin
              state <= S_ISSUE;
            end
          end else begin
            state <= S_GWAIT;
          end
        end

        S_GWAIT: begin
          if (alu_done) begin
            gb    <= ga;
            ga    <= alu_rem;
            state <= S_GCD;
          end
        end

        S_WAIT: begin
          if (alu_done) begin
            step  <= step + 1'b1;
            state <= S_ISSUE;
          end
        end

        S_OUT: begin
          if (zdiv) begin
            result.res_num <= '0;
            result.res_den <= '0;
            result.status  <= ST_ZDIV;
          end else begin
            result.res_num <= to_field(rn);
            result.res_den <= to_field(rd);
            result.status  <= (fits(rn) && fits(rd)) ? ST_OK : ST_OVF;
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### dv/tb_top.sv
module tb_top;
  import rau_pkg::*;

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } sm_t;

  typedef struct packed {
    sm_t n;
    sm_t d;
  } ratio_t;

  localparam int GAP_MAX     = 17;
  localparam int DRAIN_WAIT  = 20000;
  localparam longint LIMIT   = 40000000;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  rau_in_t  cmd;
  logic     done;
  rau_out_t result;

  rational_arithmetic_unit dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  // ---------------------------------------------------------------------------
  // Predictor: sign/magnitude arithmetic, 64-bit magnitudes that wrap like
  // unsigned 64-bit integers.
  // ---------------------------------------------------------------------------
  function automatic sm_t sm_make(logic neg, logic [MAG_W-1:0] mag);
    sm_t s;
    s.neg = neg && (mag != '0);
    s.mag = mag;
    return s;
  endfunction

  function automatic sm_t sm_rem(sm_t a, sm_t b);
    return sm_make(a.neg, a.mag % b.mag);
  endfunction

  function automatic sm_t sm_quot(sm_t a, sm_t b);
    return sm_make(a.neg != b.neg, a.mag / b.mag);
  endfunction

  function automatic sm_t sm_prod(sm_t a, sm_t b);
    logic [MAG_W-1:0] p;
    p = a.mag * b.mag;
    return sm_make(a.neg != b.neg, p);
  endfunction

  function automatic sm_t sm_sum(sm_t a, sm_t b);
    logic [MAG_W-1:0] s;
    if (a.neg == b.neg) begin
      s = a.mag + b.mag;
      return sm_make(a.neg, s);
    end
    if (a.mag >= b.mag) return sm_make(a.neg, a.mag - b.mag);
    return sm_make(b.neg, b.mag - a.mag);
  endfunction

  // Euclid with truncating remainder; the sign of the divisor falls out of it
  function automatic sm_t sm_euclid(sm_t a, sm_t b);
    sm_t r;
    while (a.mag != '0) begin
      r = sm_rem(b, a);
      b = a;
      a = r;
    end
    return b;
  endfunction

  function automatic sm_t sm_from_field(logic [FIELD_W-1:0] v);
    logic [MAG_W-1:0] ext;
    ext = {32'd0, v};
    if (v[FIELD_W-1]) return sm_make(1'b1, (64'd1 << 32) - ext);
    return sm_make(1'b0, ext);
  endfunction

  function automatic logic [FIELD_W-1:0] sm_to_field(sm_t a);
    logic [MAG_W-1:0] bits;
    bits = a.neg ? (64'd0 - a.mag) : a.mag;
    return bits[FIELD_W-1:0];
  endfunction

  function automatic logic sm_fits(sm_t a);
    logic [MAG_W-1:0] lim;
    lim = 64'd1 << (FIELD_W - 1);
    return a.neg ? (a.mag <= lim) : (a.mag < lim);
  endfunction

  function automatic ratio_t reduce_ratio(sm_t n, sm_t d);
    ratio_t r;
    sm_t g;
    if (n.mag == '0 && d.mag == '0) begin
      r.n = n; r.d = d;
    end else if (d.mag == '0) begin
      r.n = sm_make(1'b0, 64'd1); r.d = sm_make(1'b0, 64'd0);
    end else if (n.mag == '0) begin
      r.n = sm_make(1'b0, 64'd0); r.d = sm_make(1'b0, 64'd1);
    end else begin
      g = sm_euclid(n, d);
      r.n = sm_quot(n, g);
      r.d = sm_quot(d, g);
    end
    return r;
  endfunction

  function automatic ratio_t sum_ratio(ratio_t a, ratio_t b);
    ratio_t r;
    sm_t g, l, n;
    if (b.n.mag == '0) return a;
    if (a.d.mag == '0 || b.d.mag == '0) begin
      r.n = sm_make(1'b0, 64'd1); r.d = sm_make(1'b0, 64'd0);
      return r;
    end
    if (a.n.mag == '0) return b;
    g = sm_euclid(a.d, b.d);
    l = sm_prod(sm_quot(a.d, g), b.d);
    n = sm_sum(sm_prod(a.n, sm_quot(l, a.d)), sm_prod(b.n, sm_quot(l, b.d)));
    if (n.mag == '0) begin
      r.n = n; r.d = sm_make(1'b0, 64'd1);
      return r;
    end
    r.n = n;
    r.d = l;
    // a plain +1 on either side is left alone
    if ((!l.neg && l.mag == 64'd1) || (!n.neg && n.mag == 64'd1)) return r;
    g = sm_euclid(n, l);
    r.n = sm_quot(n, g);
    r.d = sm_quot(l, g);
    return r;
  endfunction

  function automatic rau_out_t predict_rational(rau_in_t c);
    rau_out_t o;
    ratio_t a, b, r;
    sm_t g1, g2;
    a.n = sm_from_field(c.a_num);
    a.d = sm_from_field(c.a_den);
    b.n = sm_from_field(c.b_num);
    b.d = sm_from_field(c.b_den);
    case (c.mode)
      MODE_NORM: r = reduce_ratio(a.n, a.d);
      MODE_ADD:  r = sum_ratio(a, b);
      MODE_MUL: begin
        g1 = sm_euclid(a.n, b.d);
        g2 = sm_euclid(b.n, a.d);
        if (g1.mag == '0 || g2.mag == '0) begin
          o.res_num = '0;
          o.res_den = '0;
          o.status  = ST_ZDIV;
          return o;
        end
        r.n = sm_prod(sm_quot(a.n, g1), sm_quot(b.n, g2));
        r.d = sm_prod(sm_quot(a.d, g2), sm_quot(b.d, g1));
      end
      default:   r = reduce_ratio(sm_make(!a.n.neg, a.n.mag), a.d);
    endcase
    o.res_num = sm_to_field(r.n);
    o.res_den = sm_to_field(r.d);
    o.status  = (sm_fits(r.n) && sm_fits(r.d)) ? ST_OK : ST_OVF;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus storage
  // ---------------------------------------------------------------------------
  rau_in_t  pending_cmds[$];
  bit       pause_flags[$];   // hold the item until every result is back
  bit       no_gap_flags[$];  // stretches with back-to-back commands
  rau_out_t expected_results[$];

  int     mismatches = 0;
  bit     taken;
  int     gap_left = 0;
  longint cycles = 0;

  // Draw a field value: half small or with shared factors so GCDs bite,
  // plus extremes, mid-range values and full-range noise.
  function automatic logic [31:0] pick_value();
    int sel;
    int f;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1, 2: return 32'($signed($urandom_range(0, 40)) - 20);
      3, 4: begin
        f = $urandom_range(1, 12);
        return 32'(f * ($signed($urandom_range(0, 2000)) - 1000));
      end
      5: return $urandom_range(0, 3) == 0 ? 32'h8000_0000 :
                $urandom_range(0, 2) == 0 ? 32'h7FFF_FFFF :
                $urandom_range(0, 1) == 0 ? 32'hFFFF_FFFF : 32'h0;
      6: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      default: return $urandom();
    endcase
  endfunction

  task automatic queue_cmd(logic [1:0] m, logic [31:0] an, logic [31:0] ad,
                           logic [31:0] bn, logic [31:0] bd, bit pause, bit nogap);
    rau_in_t c;
    c.mode  = m;
    c.a_num = an;
    c.a_den = ad;
    c.b_num = bn;
    c.b_den = bd;
    pending_cmds = {pending_cmds, c};
    pause_flags  = {pause_flags, pause};
    no_gap_flags = {no_gap_flags, nogap};
  endtask

  // ---------------------------------------------------------------------------
  // Clock and reset
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Driver: change inputs on the falling edge; one assignment per signal
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    logic    nxt_start;
    rau_in_t nxt_cmd;
    bit      free;
    nxt_start = start;
    nxt_cmd   = cmd;
    if (rst) begin
      nxt_start = 1'b0;
      nxt_cmd   = '0;
    end else begin
      free = !start;
      if (start && taken) begin
        // transaction went through on the last edge: draw the gap before the next
        free = 1'b1;
        nxt_start = 1'b0;
      end
      if (free) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_cmds.size() > 0) begin
          // a paused item waits for the block to drain completely
          if (!(pause_flags[0] && expected_results.size() > 0)) begin
            nxt_cmd   = pending_cmds.pop_front();
            void'(pause_flags.pop_front());
            gap_left  = no_gap_flags.pop_front() ? 0 : $urandom_range(0, GAP_MAX);
            nxt_start = 1'b1;
          end
        end
      end
    end
    start <= nxt_start;
    cmd   <= nxt_cmd;
  end

  // ---------------------------------------------------------------------------
  // Monitor: sample on the rising edge, check results, record accepted commands
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    rau_out_t exp_r;
    taken = 1'b0;
    if (!rst) begin
      if (done) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result num=%h den=%h status=%0d",
                     result.res_num, result.res_den, result.status);
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r.res_num !== result.res_num || exp_r.res_den !== result.res_den ||
              exp_r.status !== result.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected num=%h den=%h status=%0d, got num=%h den=%h status=%0d",
                       exp_r.res_num, exp_r.res_den, exp_r.status,
                       result.res_num, result.res_den, result.status);
          end
        end
      end
      if (start && !busy) begin
        expected_results = {expected_results, predict_rational(cmd)};
        taken = 1'b1;
      end
    end
  end

  // Timeout guard
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [1:0] m;

    // directed: constructor special cases, extremes, every mode
    queue_cmd(MODE_NORM, 0, 0, 0, 0, 1'b0, 1'b0);
    queue_cmd(MODE_NORM, 7, 0, 0, 0, 1'b0, 1'b0);
    queue_cmd(MODE_NORM, 0, -5, 0, 0, 1'b0, 1'b0);
    queue_cmd(MODE_NORM, 2, -4, 0, 0, 1'b0, 1'b1);
    queue_cmd(MODE_NORM, 32'h8000_0000, -1, 0, 0, 1'b0, 1'b1);
    queue_cmd(MODE_NORM, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 1'b0, 1'b0);
    queue_cmd(MODE_NEG, 32'h8000_0000, 1, 0, 0, 1'b0, 1'b0);
    queue_cmd(MODE_NEG, 6, -9, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0);
    queue_cmd(MODE_NEG, 0, 0, 0, 0, 1'b0, 1'b0);
    queue_cmd(MODE_ADD, 3, 4, 0, 0, 1'b0, 1'b0);
    queue_cmd(MODE_ADD, 3, 0, 1, 2, 1'b0, 1'b0);
    queue_cmd(MODE_ADD, 3, 4, 1, 0, 1'b0, 1'b0);
    queue_cmd(MODE_ADD, 0, 4, 5, -6, 1'b0, 1'b0);
    queue_cmd(MODE_ADD, 1, 2, -1, 2, 1'b0, 1'b0);
    queue_cmd(MODE_ADD, 1, 3, 1, 6, 1'b0, 1'b0);
    queue_cmd(MODE_ADD, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 1, 1'b0, 1'b0);
    queue_cmd(MODE_ADD, 1, 32'h8000_0000, 1, 32'h7FFF_FFFF, 1'b0, 1'b0);
    queue_cmd(MODE_MUL, 2, 3, 9, 4, 1'b0, 1'b0);
    queue_cmd(MODE_MUL, 0, 3, 5, 0, 1'b0, 1'b0);
    queue_cmd(MODE_MUL, 5, 3, 0, 0, 1'b0, 1'b0);
    queue_cmd(MODE_MUL, 32'h8000_0000, 1, 32'h8000_0000, 1, 1'b0, 1'b0);
    queue_cmd(MODE_MUL, -4, 7, 7, -2, 1'b1, 1'b0);
    queue_cmd(MODE_MUL, 32'h7FFF_FFFF, 3, 32'h7FFF_FFFF, 5, 1'b0, 1'b0);

    // random part
    for (int i = 0; i < 900; i++) begin
      m = 2'($urandom_range(0, 3));
      queue_cmd(m, pick_value(), $urandom_range(0, 15) == 0 ? 32'h0 : pick_value(),
                pick_value(), $urandom_range(0, 15) == 0 ? 32'h0 : pick_value(),
                (i % 300) == 150, (i / 100) % 3 == 1);
    end

    @(negedge rst);
    wait (pending_cmds.size() == 0 && !start);
    wait (expected_results.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### rational_arithmetic_unit.f
design/rau_pkg.sv
design/rau_alu.sv
design/rational_arithmetic_unit.sv
dv/tb_top.sv
